/* rtl/cssfl_pkg.sv */
// ----------------------------------------------------------------------------
// cssfl_pkg
// Shared types and constants for the character-set scanner: word formats of
// both channels, request codes, configuration indexes and the queue entry.
// ----------------------------------------------------------------------------
package cssfl_pkg;

	// Request codes as they arrive on the input channel
	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_ADD   = 3'd1;
	localparam logic [2:0] REQ_SCAN  = 3'd2;
	localparam logic [2:0] REQ_END   = 3'd3;
	localparam logic [2:0] REQ_QUERY = 3'd4;

	// Configuration register indexes
	localparam logic CFG_SCAN_FROM_END = 1'b0;
	localparam logic CFG_INVERT_MATCH  = 1'b1;

	// Highest code held in the bitmap
	localparam int LOW_LIMIT = 255;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] char_code;
	} in_word_t;

	typedef struct packed {
		logic signed [16:0] match_index;
		logic               is_member;
		logic               set_overflow;
	} out_word_t;

	// Decoded operation carried to the back end
	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_ADD,
		OP_SCAN,
		OP_END,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] code;
	} q_entry_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

/* rtl/cssfl_front.sv */
// ----------------------------------------------------------------------------
// cssfl_front
// Accepts input words, decodes the request type and queues the decoded
// operation for the back end. Unknown requests are taken and dropped.
// ----------------------------------------------------------------------------
module cssfl_front
	import cssfl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	output q_head_t  head,
	input  logic     pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t           queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	q_entry_t           dec_entry;
	logic               dec_known;
	logic               push;
	logic               do_pop;

	// Request decode
	always_comb begin
		dec_entry.code = in_word.char_code;
		dec_entry.op   = OP_CLEAR;
		dec_known      = 1'b1;
		case (in_word.req_type)
			REQ_CLEAR: dec_entry.op = OP_CLEAR;
			REQ_ADD:   dec_entry.op = OP_ADD;
			REQ_SCAN:  dec_entry.op = OP_SCAN;
			REQ_END:   dec_entry.op = OP_END;
			REQ_QUERY: dec_entry.op = OP_QUERY;
			default:   dec_known    = 1'b0;
		endcase
	end

	assign in_stall = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && dec_known;
	assign do_pop   = pop && (count_q != '0);

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec_entry;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = queue_q[rd_ptr_q];

endmodule

/* rtl/cssfl_back.sv */
// ----------------------------------------------------------------------------
// cssfl_back
// Carries out queued operations on the set and the scan state: bitmap for
// small codes, a parallel-compare table for large ones, scan position and
// hit tracking, and a result register towards the output channel.
// ----------------------------------------------------------------------------
module cssfl_back
	import cssfl_pkg::*;
#(
	parameter int HIGH_ENTRIES = 16,
	parameter int SPAN_MAX     = 65536
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_data,
	input  q_head_t   head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int CNT_W = $clog2(HIGH_ENTRIES + 1);
	localparam int POS_W = $clog2(SPAN_MAX + 1);
	localparam int HIT_W = $clog2(SPAN_MAX);

	logic                 scan_from_end_q;
	logic                 invert_match_q;
	logic [LOW_LIMIT:0]   low_bitmap_q;
	logic [15:0]          high_table_q [HIGH_ENTRIES];
	logic [CNT_W-1:0]     high_count_q;
	logic [POS_W-1:0]     position_q;
	logic                 hit_seen_q;
	logic [HIT_W-1:0]     hit_position_q;
	logic                 overflow_seen_q;
	logic                 result_valid_q;
	out_word_t            result_q;

	logic                 is_low;
	logic                 in_table;
	logic                 member;
	logic                 needs_out;
	logic                 out_free;
	logic                 add_new;
	logic                 in_span;
	logic                 take_hit;
	q_entry_t             ent;
	out_word_t            result_d;

	assign ent = head.entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_from_end_q <= 1'b0;
			invert_match_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SCAN_FROM_END) begin
				scan_from_end_q <= cfg_data;
			end
			if (cfg_index == CFG_INVERT_MATCH) begin
				invert_match_q <= cfg_data;
			end
		end
	end

	// Membership: bitmap lookup or compare against every filled table entry
	always_comb begin
		in_table = 1'b0;
		for (int i = 0; i < HIGH_ENTRIES; i++) begin
			if ((CNT_W'(i) < high_count_q) && (high_table_q[i] == ent.code)) begin
				in_table = 1'b1;
			end
		end
	end

	assign is_low = (ent.code[15:8] == 8'd0);
	assign member = is_low ? low_bitmap_q[ent.code[7:0]] : in_table;

	// Issue control: result-producing ops wait for the result register
	assign needs_out = (ent.op == OP_END) || (ent.op == OP_QUERY);
	assign out_free  = !result_valid_q || !out_stall;
	assign pop       = head.valid && (!needs_out || out_free);

	assign add_new  = pop && (ent.op == OP_ADD) && !is_low && !in_table;
	assign in_span  = (position_q < POS_W'(SPAN_MAX));
	assign take_hit = (member == !invert_match_q) && (scan_from_end_q || !hit_seen_q);

	// Large-code table, written at the next free slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < HIGH_ENTRIES; i++) begin
			if (add_new && (high_count_q == CNT_W'(i))) begin
				high_table_q[i] <= ent.code;
			end
		end
	end

	// Set and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bitmap_q    <= '0;
			high_count_q    <= '0;
			overflow_seen_q <= 1'b0;
			position_q      <= '0;
			hit_seen_q      <= 1'b0;
			hit_position_q  <= '0;
		end else if (pop) begin
			case (ent.op)
				OP_CLEAR: begin
					low_bitmap_q    <= '0;
					high_count_q    <= '0;
					overflow_seen_q <= 1'b0;
				end
				OP_ADD: begin
					if (is_low) begin
						low_bitmap_q[ent.code[7:0]] <= 1'b1;
					end else if (add_new) begin
						if (high_count_q < CNT_W'(HIGH_ENTRIES)) begin
							high_count_q <= high_count_q + 1'b1;
						end else begin
							overflow_seen_q <= 1'b1;
						end
					end
				end
				OP_SCAN: begin
					if (in_span) begin
						if (take_hit) begin
							hit_position_q <= HIT_W'(position_q);
							hit_seen_q     <= 1'b1;
						end
						position_q <= position_q + 1'b1;
					end
				end
				OP_END: begin
					position_q     <= '0;
					hit_seen_q     <= 1'b0;
					hit_position_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result word
	always_comb begin
		result_d.set_overflow = overflow_seen_q;
		if (ent.op == OP_QUERY) begin
			result_d.match_index = '0;
			result_d.is_member   = member;
		end else begin
			result_d.match_index = hit_seen_q ? $signed(17'(hit_position_q)) : -17'sd1;
			result_d.is_member   = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= pop && needs_out;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && needs_out) begin
			result_q <= result_d;
		end
	end

	assign out_valid = result_valid_q;
	assign out_word  = result_q;

endmodule

/* rtl/char_set_scan_first_last_unit.sv */
// ----------------------------------------------------------------------------
// char_set_scan_first_last_unit
// Character-set scanner: set of 16-bit codes, span scan for the first or
// last (non-)member position, and membership queries.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while in_stall is low. A word enters a
// two-entry queue and is carried out by the back end once it is at the head
// of the queue and, for an end-scan or query, the output register is free.
// An end-scan or query result is loaded into the output register at the edge
// on which its word is carried out. The back end does the bitmap lookup and
// the compare against all HIGH_ENTRIES table entries combinationally. The
// output register lets the input keep flowing while a result waits; only when
// results back up does the queue fill and raise in_stall. Configuration must be
// written only while the block is idle; the block does not enforce this.
module char_set_scan_first_last_unit
	import cssfl_pkg::*;
#(
	parameter int HIGH_ENTRIES = 16,
	parameter int SPAN_MAX     = 65536
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	q_head_t head;
	logic    pop;

	cssfl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.head     (head),
		.pop      (pop)
	);

	cssfl_back #(
		.HIGH_ENTRIES (HIGH_ENTRIES),
		.SPAN_MAX     (SPAN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// A result-producing op must not issue over a held result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(head.valid && (head.entry.op == OP_END || head.entry.op == OP_QUERY)
			&& out_valid && out_stall) |-> !pop)
		else $error("result op issued while output held");

	// An issued end-scan or query shows up on the output next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (head.entry.op == OP_END || head.entry.op == OP_QUERY)) |=> out_valid)
		else $error("issued result op gave no result");

	// A fresh result only comes from an issued result op
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && (head.entry.op == OP_END
			|| head.entry.op == OP_QUERY)))
		else $error("result appeared without an issued op");

endmodule
